### hw/rtl/qpht_pkg.sv
// Shared types, constants and modular helpers for the quadratic-probe hash table.
// Depends on nothing; imported by quadratic_probe_hash_table.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

  // Table geometry
  localparam int unsigned TABLE_SIZE = 1021;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned COEFF_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned PROBES_W = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Key and coefficient reduction: RED_BITS bits folded in per cycle, MSB first
  localparam int unsigned RED_BITS  = 4;
  localparam int unsigned RED_STEPS = (KEY_W + RED_BITS - 1) / RED_BITS;
  localparam int unsigned PAD_W     = RED_STEPS * RED_BITS;
  localparam int unsigned RED_CNT_W = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  localparam logic [IDX_W:0] SIZE_X = (IDX_W + 1)'(TABLE_SIZE);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_COEFF = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PROBES_W-1:0] probes;
  } result_t;

  // (a + b) mod TABLE_SIZE for a, b already below TABLE_SIZE
  function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SIZE_X) begin
      sum = sum - SIZE_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  // Fold RED_BITS more bits into a running remainder, MSB first
  function automatic logic [IDX_W-1:0] red_chunk(input logic [IDX_W-1:0]    r,
                                                 input logic [RED_BITS-1:0] bits);
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] acc;
    acc = r;
    for (int i = RED_BITS - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= SIZE_X) begin
        t = t - SIZE_X;
      end
      acc = t[IDX_W-1:0];
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/quadratic_probe_hash_table.sv
// Quadratic-probe open-addressing key table with a single-port slot memory.
// Depends on qpht_pkg for types, constants and the modular helpers.
`timescale 1ns / 1ps
`default_nettype none

// Key table of TABLE_SIZE (1021) slots, probed at (key + c1*i + c2*i*i) mod size.
// A command is taken when start is high and busy is low; one result item
// follows, shown on result_o for a single cycle with result_valid_o high. The
// receiver cannot stall, so every result must be sampled in that cycle.
// Insert and search reduce the key and both coefficients modulo the size in
// RED_STEPS (8) steps, then pass a setup state and walk the probes; the memory
// read and the result are both registered. The probe walk is bound by the
// single port of the slot memory, one read per cycle. Clear sweeps every slot,
// one per cycle. Unused op code three answers straight away with a miss. After
// reset the block runs the same clearing pass with busy high and gives no
// result. Coefficient writes are taken in any cycle, but only change the
// outcome of commands that start later.
module quadratic_probe_hash_table
  import qpht_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command channel
  input  wire logic                 start,
  output      logic                 busy,
  input  wire cmd_t                 cmd_i,
  // result channel
  output      logic                 result_valid_o,
  output      result_t              result_o,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COEFF_W-1:0]   cfg_data_i
);

  localparam int unsigned MEM_W = KEY_W + 1;   // {valid, key}

  localparam logic [IDX_W-1:0]     IDX_LAST   = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0]     CNT_SIZE   = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]     CNT_LAST   = CNT_W'(TABLE_SIZE - 1);
  localparam logic [RED_CNT_W-1:0] RED_LAST   = RED_CNT_W'(RED_STEPS - 1);
  localparam logic [COEFF_W-1:0]   COEFF_INIT = COEFF_W'(1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_REDUCE = 5'b00100,
    S_SETUP  = 5'b01000,
    S_PROBE  = 5'b10000
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic                 ins_q, ins_d;            // current walk is an insert
  logic                 clr_rsp_q, clr_rsp_d;    // clearing pass answers a command
  logic [IDX_W-1:0]     clr_idx_q, clr_idx_d;
  logic [RED_CNT_W-1:0] red_cnt_q, red_cnt_d;
  logic [CNT_W-1:0]     issued_q, issued_d;      // reads issued in this walk
  logic [CNT_W-1:0]     probe_cnt_q, probe_cnt_d;// slots examined so far
  logic                 flight_v_q, flight_v_d;  // a read returns this cycle
  logic                 result_valid_q, result_valid_d;
  logic [COEFF_W-1:0]   lin_coeff_q, lin_coeff_d;
  logic [COEFF_W-1:0]   sq_coeff_q, sq_coeff_d;

  // payload, no reset
  logic [KEY_W-1:0]     key_q, key_d;
  logic [PAD_W-1:0]     key_sh_q, key_sh_d;
  logic [PAD_W-1:0]     lin_sh_q, lin_sh_d;
  logic [PAD_W-1:0]     sq_sh_q, sq_sh_d;
  logic [IDX_W-1:0]     key_r_q, key_r_d;        // key mod size
  logic [IDX_W-1:0]     a_q, a_d;                // linear coeff mod size
  logic [IDX_W-1:0]     b_q, b_d;                // square coeff mod size
  logic [IDX_W-1:0]     issue_addr_q, issue_addr_d;
  logic [IDX_W-1:0]     step_q, step_d;          // distance to the next probe
  logic [IDX_W-1:0]     twice_q, twice_d;        // growth of that distance
  logic [IDX_W-1:0]     flight_addr_q, flight_addr_d;
  result_t              result_q, result_d;

  // slot memory
  logic [MEM_W-1:0]     slot_mem [TABLE_SIZE];
  logic [MEM_W-1:0]     rd_q;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_addr;
  logic [MEM_W-1:0]     mem_wdata;

  // probe evaluation
  logic                 slot_used, slot_same, walk_stop;
  logic [CNT_W-1:0]     probes_new;

  assign slot_used  = rd_q[KEY_W];
  assign slot_same  = slot_used && (rd_q[KEY_W-1:0] == key_q);
  assign probes_new = probe_cnt_q + CNT_W'(1);
  // stop on a match, on an empty slot, or when every slot has been seen
  assign walk_stop  = slot_same || !slot_used || (probe_cnt_q == CNT_LAST);

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;
  assign cfg_ready_o    = 1'b1;

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    ins_d          = ins_q;
    clr_rsp_d      = clr_rsp_q;
    clr_idx_d      = clr_idx_q;
    red_cnt_d      = red_cnt_q;
    issued_d       = issued_q;
    probe_cnt_d    = probe_cnt_q;
    flight_v_d     = 1'b0;
    result_valid_d = 1'b0;
    lin_coeff_d    = lin_coeff_q;
    sq_coeff_d     = sq_coeff_q;
    key_d          = key_q;
    key_sh_d       = key_sh_q;
    lin_sh_d       = lin_sh_q;
    sq_sh_d        = sq_sh_q;
    key_r_d        = key_r_q;
    a_d            = a_q;
    b_d            = b_q;
    issue_addr_d   = issue_addr_q;
    step_d         = step_q;
    twice_d        = twice_q;
    flight_addr_d  = flight_addr_q;
    result_d       = result_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = issue_addr_q;
    mem_wdata      = {1'b1, key_q};

    // coefficient writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LINEAR_COEFF: lin_coeff_d = cfg_data_i;
        CFG_SQUARE_COEFF: sq_coeff_d  = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ins_d    = (cmd_i.op == OP_INSERT);
          key_d    = cmd_i.key;
          key_sh_d = PAD_W'(cmd_i.key);
          lin_sh_d = PAD_W'(lin_coeff_q);
          sq_sh_d  = PAD_W'(sq_coeff_q);
          key_r_d  = '0;
          a_d      = '0;
          b_d      = '0;
          red_cnt_d = '0;
          case (cmd_i.op) inside
            OP_INSERT, OP_SEARCH: begin
              state_d = S_REDUCE;
            end
            OP_CLEAR: begin
              clr_idx_d = '0;
              clr_rsp_d = 1'b1;
              state_d   = S_CLEAR;
            end
            default: begin
              // unused code: table untouched, answer at once
              result_d       = '{status: STATUS_MISS, slot: '0, probes: '0};
              result_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_CLEAR: begin
        // empty one slot per cycle
        mem_we    = 1'b1;
        mem_addr  = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_LAST) begin
          state_d        = S_IDLE;
          result_d       = '{status: STATUS_OK, slot: '0, probes: '0};
          result_valid_d = clr_rsp_q;
        end
      end

      S_REDUCE: begin
        // fold the next chunk of key and both coefficients, MSB first
        key_r_d  = red_chunk(key_r_q, key_sh_q[PAD_W-1 -: RED_BITS]);
        a_d      = red_chunk(a_q, lin_sh_q[PAD_W-1 -: RED_BITS]);
        b_d      = red_chunk(b_q, sq_sh_q[PAD_W-1 -: RED_BITS]);
        key_sh_d = key_sh_q << RED_BITS;
        lin_sh_d = lin_sh_q << RED_BITS;
        sq_sh_d  = sq_sh_q << RED_BITS;
        red_cnt_d = red_cnt_q + RED_CNT_W'(1);
        if (red_cnt_q == RED_LAST) begin
          state_d = S_SETUP;
        end
      end

      S_SETUP: begin
        issue_addr_d = key_r_q;
        step_d       = add_mod(a_q, b_q);
        twice_d      = add_mod(b_q, b_q);
        issued_d     = '0;
        probe_cnt_d  = '0;
        state_d      = S_PROBE;
      end

      S_PROBE: begin
        if (flight_v_q && walk_stop) begin
          // finish: an insert writes the key on a match or into the empty slot
          state_d        = S_IDLE;
          result_valid_d = 1'b1;
          result_d.probes = PROBES_W'(probes_new);
          if (slot_same || (ins_q && !slot_used)) begin
            mem_we          = ins_q;
            mem_addr        = flight_addr_q;
            result_d.status = STATUS_OK;
            result_d.slot   = SLOT_W'(flight_addr_q);
          end else begin
            result_d.status = (ins_q && slot_used) ? STATUS_OVERFLOW : STATUS_MISS;
            result_d.slot   = '0;
          end
        end else begin
          if (flight_v_q) begin
            probe_cnt_d = probes_new;
          end
          // advance the probe sequence while slots remain
          if (issued_q != CNT_SIZE) begin
            mem_re        = 1'b1;
            flight_v_d    = 1'b1;
            flight_addr_d = issue_addr_q;
            issue_addr_d  = add_mod(issue_addr_q, step_q);
            step_d        = add_mod(step_q, twice_q);
            issued_d      = issued_q + CNT_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers; reset starts a clearing pass
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      ins_q          <= 1'b0;
      clr_rsp_q      <= 1'b0;
      clr_idx_q      <= '0;
      red_cnt_q      <= '0;
      issued_q       <= '0;
      probe_cnt_q    <= '0;
      flight_v_q     <= 1'b0;
      result_valid_q <= 1'b0;
      lin_coeff_q    <= COEFF_INIT;
      sq_coeff_q     <= COEFF_INIT;
    end else begin
      state_q        <= state_d;
      ins_q          <= ins_d;
      clr_rsp_q      <= clr_rsp_d;
      clr_idx_q      <= clr_idx_d;
      red_cnt_q      <= red_cnt_d;
      issued_q       <= issued_d;
      probe_cnt_q    <= probe_cnt_d;
      flight_v_q     <= flight_v_d;
      result_valid_q <= result_valid_d;
      lin_coeff_q    <= lin_coeff_d;
      sq_coeff_q     <= sq_coeff_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    key_sh_q      <= key_sh_d;
    lin_sh_q      <= lin_sh_d;
    sq_sh_q       <= sq_sh_d;
    key_r_q       <= key_r_d;
    a_q           <= a_d;
    b_q           <= b_d;
    issue_addr_q  <= issue_addr_d;
    step_q        <= step_d;
    twice_q       <= twice_d;
    flight_addr_q <= flight_addr_d;
    result_q      <= result_d;
  end

  // Single-port slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_q <= slot_mem[mem_addr];
    end
  end

endmodule

`default_nettype wire
